FILE: rtl/core/hashed_token_embedding_macros.svh
// ----------------------------------------------------------------------------
// hashed_token_embedding_macros.svh
// Assertion macros for the hashed token embedding core.
// ----------------------------------------------------------------------------
`ifndef HASHED_TOKEN_EMBEDDING_MACROS_SVH
`define HASHED_TOKEN_EMBEDDING_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, masked while reset is asserted.
`define HTE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("hte assertion failed");

// Clocked check that also holds through reset.
`define HTE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("hte assertion failed");

`else

`define HTE_ASSERT(lbl, clk, rstn, prop)
`define HTE_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: rtl/core/hte_pkg.sv
// ----------------------------------------------------------------------------
// hte_pkg
// Constants, types and helpers of the hashed token embedding core.
// ----------------------------------------------------------------------------
package hte_pkg;

    localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME  = 64'h00000100000001b3;
    localparam logic [63:0] PAIR_SEED  = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] PAIR_MUL   = 64'h517cc1b727220a95;
    localparam logic [63:0] MIX_C1     = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2     = 64'hc4ceb9fe1a85ec53;

    localparam int unsigned MIX_SHIFT   = 33;
    localparam int unsigned MAG_W       = 24;
    localparam int unsigned IDX_W       = 6;
    localparam int unsigned DIM_W       = 7;
    localparam logic [6:0]  DIM_MAX     = 7'd64;
    localparam logic [6:0]  DIM_RESET   = 7'd64;
    localparam logic [1:0]  MUL_LAST    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_CHAR,
        ST_MUL_PAIR,
        ST_PRE,
        ST_MIX1,
        ST_MIX2,
        ST_PUT,
        ST_ZERO
    } state_t;

    function automatic logic [63:0] sext8(input logic [7:0] v);
        sext8 = {{56{v[7]}}, v};
    endfunction

    function automatic logic [63:0] xor_shift(input logic [63:0] v);
        xor_shift = v ^ (v >> MIX_SHIFT);
    endfunction

endpackage

FILE: rtl/core/hashed_token_embedding.sv
// ----------------------------------------------------------------------------
// hashed_token_embedding
// FNV-1a character hash plus pair hash per token; on the last character
// emits murmur3-finalized components (sign + 24-bit magnitude).
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                   | side band
//  s_       | in  | [7:0] char_value                        | tlast last_char,
//           |     |                                         | tuser empty_token
//  m_       | out | [5:0] index, [6] positive, [30:7] mag   | tlast last_component
//  cfg_wr_  | in  | [6:0] dimension                         | write enable
//
//  A character is accepted, then goes through two 64-bit multiplies on the
//  single 32x32 multiplier (one when it is the first character).
//  Each component goes through pre-mix, two multiplies and the output load.
//  An empty token emits one zero component per cycle while m_ is not stalled.
//  Reset is synchronous, active low; it restores the hashes and dimension 64.
//  A stalled m_ side holds the sequencer in its output-load state.
// ----------------------------------------------------------------------------
`include "hashed_token_embedding_macros.svh"

module hashed_token_embedding (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_value
    input  logic        s_tlast,
    input  logic        s_tuser,   // [0] empty_token
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [5:0] component_index, [6] positive,
                                   // [30:7] magnitude, [31] zero fill
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data
);

    hte_pkg::state_t state_reg, state_next;

    logic [1:0]  step_reg, step_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] ch_reg, ch_next;
    logic [63:0] ph_reg, ph_next;
    logic [63:0] sum_reg, sum_next;
    logic [7:0]  prev_reg, prev_next;
    logic        have_prev_reg, have_prev_next;
    logic [7:0]  char_reg, char_next;
    logic        last_reg, last_next;
    logic [5:0]  idx_reg, idx_next;
    logic [6:0]  dim_reg;

    logic        out_valid_reg, out_valid_next;
    logic [5:0]  out_idx_reg, out_idx_next;
    logic        out_pos_reg, out_pos_next;
    logic [23:0] out_mag_reg, out_mag_next;
    logic        out_last_reg, out_last_next;

    // shared multiplier
    logic [63:0] mul_b;
    logic [31:0] a_half, b_half;
    logic [63:0] prod;
    logic [63:0] mul_res;

    logic        mul_done;
    logic        out_free;
    logic [6:0]  eff_dim;
    logic [5:0]  last_idx;
    logic        is_last;
    logic        out_load;
    logic [63:0] pair_word;
    logic [63:0] sum_first;

    always_comb begin
        case (state_reg)
            hte_pkg::ST_MUL_CHAR: mul_b = hte_pkg::FNV_PRIME;
            hte_pkg::ST_MUL_PAIR: mul_b = hte_pkg::PAIR_MUL;
            hte_pkg::ST_MIX1:     mul_b = hte_pkg::MIX_C1;
            hte_pkg::ST_MIX2:     mul_b = hte_pkg::MIX_C2;
            default:              mul_b = '0;
        endcase
    end

    // low 64 bits of a*b: lo*lo, then the two cross terms shifted by 32
    assign a_half  = (step_reg == hte_pkg::MUL_LAST) ? a_reg[63:32] : a_reg[31:0];
    assign b_half  = (step_reg == 2'd1) ? mul_b[63:32] : mul_b[31:0];
    assign prod    = a_half * b_half;
    assign mul_res = (step_reg == 2'd0) ? prod : (acc_reg + {prod[31:0], 32'd0});
    assign mul_done = (step_reg == hte_pkg::MUL_LAST);

    assign eff_dim  = (dim_reg == 7'd0) ? 7'd1 :
                      (dim_reg > hte_pkg::DIM_MAX) ? hte_pkg::DIM_MAX : dim_reg;
    assign last_idx = 6'(eff_dim - 7'd1);
    assign is_last  = (idx_reg == last_idx);
    assign out_free = !out_valid_reg || m_tready;

    assign pair_word = {{48{prev_reg[7]}}, prev_reg, 8'd0} | hte_pkg::sext8(char_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hte_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = s_tuser ? hte_pkg::ST_ZERO : hte_pkg::ST_MUL_CHAR;
                end
            end
            hte_pkg::ST_MUL_CHAR: begin
                if (mul_done) begin
                    if (have_prev_reg) begin
                        state_next = hte_pkg::ST_MUL_PAIR;
                    end else if (last_reg) begin
                        state_next = hte_pkg::ST_PRE;
                    end else begin
                        state_next = hte_pkg::ST_IDLE;
                    end
                end
            end
            hte_pkg::ST_MUL_PAIR: begin
                if (mul_done) begin
                    state_next = last_reg ? hte_pkg::ST_PRE : hte_pkg::ST_IDLE;
                end
            end
            hte_pkg::ST_PRE: begin
                state_next = hte_pkg::ST_MIX1;
            end
            hte_pkg::ST_MIX1: begin
                if (mul_done) begin
                    state_next = hte_pkg::ST_MIX2;
                end
            end
            hte_pkg::ST_MIX2: begin
                if (mul_done) begin
                    state_next = hte_pkg::ST_PUT;
                end
            end
            hte_pkg::ST_PUT: begin
                if (out_free) begin
                    state_next = is_last ? hte_pkg::ST_IDLE : hte_pkg::ST_PRE;
                end
            end
            hte_pkg::ST_ZERO: begin
                if (out_free && is_last) begin
                    state_next = hte_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hte_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        step_next      = 2'd0;
        a_next         = a_reg;
        acc_next       = mul_res;
        ch_next        = ch_reg;
        ph_next        = ph_reg;
        sum_next       = sum_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_idx_next   = out_idx_reg;
        out_pos_next   = out_pos_reg;
        out_mag_next   = out_mag_reg;
        out_last_next  = out_last_reg;
        sum_first      = ch_reg + ph_reg;
        s_tready       = 1'b0;

        case (state_reg)
            hte_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                char_next = s_tdata;
                last_next = s_tlast;
                a_next    = ch_reg ^ hte_pkg::sext8(s_tdata);
                idx_next  = '0;
                if (s_tvalid && s_tuser) begin
                    ch_next        = hte_pkg::FNV_OFFSET;
                    ph_next        = hte_pkg::PAIR_SEED;
                    prev_next      = '0;
                    have_prev_next = 1'b0;
                end
            end
            hte_pkg::ST_MUL_CHAR: begin
                step_next = step_reg + 2'd1;
                if (mul_done) begin
                    step_next      = 2'd0;
                    ch_next        = mul_res;
                    a_next         = ph_reg ^ pair_word;
                    prev_next      = char_reg;
                    have_prev_next = 1'b1;
                    sum_next       = mul_res + ph_reg;
                end
            end
            hte_pkg::ST_MUL_PAIR: begin
                step_next = step_reg + 2'd1;
                if (mul_done) begin
                    step_next = 2'd0;
                    ph_next   = mul_res;
                    sum_next  = ch_reg + mul_res;
                end
            end
            hte_pkg::ST_PRE: begin
                a_next = hte_pkg::xor_shift(sum_reg);
            end
            hte_pkg::ST_MIX1, hte_pkg::ST_MIX2: begin
                step_next = step_reg + 2'd1;
                if (mul_done) begin
                    step_next = 2'd0;
                    a_next    = hte_pkg::xor_shift(mul_res);
                end
            end
            hte_pkg::ST_PUT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_pos_next  = a_reg[0];
                    out_mag_next  = a_reg[hte_pkg::MAG_W-1:0];
                    idx_next      = idx_reg + 6'd1;
                    sum_next      = sum_reg + ph_reg;
                    if (is_last) begin
                        ch_next        = hte_pkg::FNV_OFFSET;
                        ph_next        = hte_pkg::PAIR_SEED;
                        prev_next      = '0;
                        have_prev_next = 1'b0;
                    end
                end
            end
            hte_pkg::ST_ZERO: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    out_pos_next = 1'b0;
                    out_mag_next = '0;
                    idx_next     = idx_reg + 6'd1;
                end
            end
            default: begin
                sum_next = sum_first;
            end
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
            out_idx_next   = idx_reg;
            out_last_next  = is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= hte_pkg::ST_IDLE;
            step_reg      <= 2'd0;
            ch_reg        <= hte_pkg::FNV_OFFSET;
            ph_reg        <= hte_pkg::PAIR_SEED;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            idx_reg       <= '0;
            dim_reg       <= hte_pkg::DIM_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            ch_reg        <= ch_next;
            ph_reg        <= ph_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                dim_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg        <= a_next;
        acc_reg      <= acc_next;
        sum_reg      <= sum_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
        out_idx_reg  <= out_idx_next;
        out_pos_reg  <= out_pos_next;
        out_mag_reg  <= out_mag_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_mag_reg, out_pos_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

    // multiply step counter only runs inside the multiply states
    `HTE_ASSERT(a_step_in_mul, aclk, aresetn,
        (step_reg != 2'd0) |-> (state_reg == hte_pkg::ST_MUL_CHAR ||
                                state_reg == hte_pkg::ST_MUL_PAIR ||
                                state_reg == hte_pkg::ST_MIX1 ||
                                state_reg == hte_pkg::ST_MIX2))
    // final component of a vector returns the sequencer to idle
    `HTE_ASSERT(a_last_to_idle, aclk, aresetn,
        (out_load && is_last) |=> (state_reg == hte_pkg::ST_IDLE))
    // hash state is back at its seed once a computed vector is done
    `HTE_ASSERT(a_token_cleared, aclk, aresetn,
        (state_reg == hte_pkg::ST_PUT && out_load && is_last) |=>
        (!have_prev_reg && ch_reg == hte_pkg::FNV_OFFSET &&
         ph_reg == hte_pkg::PAIR_SEED))
    // empty-token components carry a zero value
    `HTE_ASSERT(a_zero_value, aclk, aresetn,
        (state_reg == hte_pkg::ST_ZERO && out_load) |=>
        (out_mag_reg == 24'd0 && !out_pos_reg))

endmodule

FILE: tb/hashed_token_embedding_tb.sv
// ----------------------------------------------------------------------------
// hashed_token_embedding_tb
// Self-checking bench for the hashed token embedding core. Characters go in
// one per item, in tokens with random content, empty tokens and cut-off
// tokens. A local model of both hashes and the finalizer predicts every
// component. The sender idles in bursts, the receiver stalls on patterns,
// and the dimension register is set to random values between phases.
// ----------------------------------------------------------------------------
module hashed_token_embedding_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [5:0]  index;
        logic        positive;
        logic [23:0] magnitude;
        logic        last;
    } component_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] char_value
    logic        s_tlast;
    logic        s_tuser;    // [0] empty_token
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [5:0] index, [6] positive, [30:7] magnitude
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;

    // local copy of the block's state
    logic [63:0] char_hash;
    logic [63:0] pair_hash;
    logic [7:0]  prev_char;
    logic        have_prev;
    logic [6:0]  dim_reg;

    component_t  expected_components[$];
    int          error_count;
    int          burst_left;
    bit          tx_bursty;
    logic [15:0] rx_pattern;
    int          rx_count;

    hashed_token_embedding dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 100) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic logic [63:0] murmur_finalize(input logic [63:0] v);
        logic [63:0] h;
        h = v ^ (v >> hte_pkg::MIX_SHIFT);
        h = h * hte_pkg::MIX_C1;
        h = h ^ (h >> hte_pkg::MIX_SHIFT);
        h = h * hte_pkg::MIX_C2;
        h = h ^ (h >> hte_pkg::MIX_SHIFT);
        return h;
    endfunction

    function automatic int active_dimension();
        int d;
        d = int'(dim_reg);
        if (d < 1) d = 1;
        if (d > int'(hte_pkg::DIM_MAX)) d = int'(hte_pkg::DIM_MAX);
        return d;
    endfunction

    task automatic clear_token_state();
        char_hash = hte_pkg::FNV_OFFSET;
        pair_hash = hte_pkg::PAIR_SEED;
        prev_char = '0;
        have_prev = 1'b0;
    endtask

    task automatic predict_components(input logic [7:0] ch, input logic last,
                                      input logic empty);
        logic [63:0] ext_char;
        logic [63:0] pair;
        logic [63:0] mixed;
        component_t  comp;
        int          d;
        d = active_dimension();
        if (empty) begin
            for (int i = 0; i < d; i++) begin
                comp.index     = 6'(i);
                comp.positive  = 1'b0;
                comp.magnitude = '0;
                comp.last      = (i + 1 == d);
                expected_components.push_back(comp);
            end
            clear_token_state();
            return;
        end
        ext_char  = {{56{ch[7]}}, ch};
        char_hash = (char_hash ^ ext_char) * hte_pkg::FNV_PRIME;
        if (have_prev) begin
            // a negative current char sets every bit above it, covering the previous one
            pair      = ({{56{prev_char[7]}}, prev_char} << 8) | ext_char;
            pair_hash = (pair_hash ^ pair) * hte_pkg::PAIR_MUL;
        end
        prev_char = ch;
        have_prev = 1'b1;
        if (!last) return;
        for (int i = 0; i < d; i++) begin
            mixed          = murmur_finalize(char_hash + pair_hash * 64'(i + 1));
            comp.index     = 6'(i);
            comp.positive  = mixed[0];
            comp.magnitude = mixed[23:0];
            comp.last      = (i + 1 == d);
            expected_components.push_back(comp);
        end
        clear_token_state();
    endtask

    // ------------------------------------------------------------------
    // drivers; every task starts and ends just after a falling edge
    // ------------------------------------------------------------------
    task automatic send_item(input logic [7:0] ch, input logic last,
                             input logic empty);
        int gap;
        if (tx_bursty) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
                burst_left = $urandom_range(1, 8);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        s_tuser  <= empty;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_components(ch, last, empty);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_components.size() != 0) @(negedge aclk);
        // a plain character can still be in the hash multiplier
        repeat (40) @(negedge aclk);
    endtask

    task automatic set_dimension(input logic [6:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        dim_reg = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] random_char();
        case ($urandom_range(0, 7))
            0:       return 8'h80;
            1:       return 8'h7f;
            2:       return 8'hff;
            3:       return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_token(input int len);
        for (int k = 0; k < len; k++) begin
            send_item(random_char(), k == len - 1, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: stall pattern changes whenever rx_count runs out
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (rx_count == 0) begin
            case ($urandom_range(0, 3))
                0:       rx_pattern = 16'hffff;
                1:       rx_pattern = 16'h00ff;
                2:       rx_pattern = 16'($urandom) | 16'h1111;
                default: rx_pattern = 16'($urandom);
            endcase
            rx_count = 64;
        end
        rx_count--;
        m_tready <= rx_pattern[rx_count % 16];
    end

    always @(posedge aclk) begin
        component_t exp_comp;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_components.size() == 0) begin
                report_mismatch($sformatf("unexpected component, tdata=%h", m_tdata));
            end else begin
                exp_comp = expected_components.pop_front();
                if (m_tdata[5:0] !== exp_comp.index)
                    report_mismatch($sformatf("index %0d, want %0d",
                                              m_tdata[5:0], exp_comp.index));
                if (m_tdata[6] !== exp_comp.positive)
                    report_mismatch($sformatf("positive %b, want %b (index %0d)",
                                              m_tdata[6], exp_comp.positive,
                                              exp_comp.index));
                if (m_tdata[30:7] !== exp_comp.magnitude)
                    report_mismatch($sformatf("magnitude %h, want %h (index %0d)",
                                              m_tdata[30:7], exp_comp.magnitude,
                                              exp_comp.index));
                if (m_tlast !== exp_comp.last)
                    report_mismatch($sformatf("tlast %b, want %b (index %0d)",
                                              m_tlast, exp_comp.last, exp_comp.index));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_dimension();
        // full 64-wide vectors straight out of reset
        send_item(8'h41, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_char_extremes();
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7f, 1'b1, 1'b0);
        // negative second char floods the pair's upper bits
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7f, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h7f, 1'b1, 1'b0);
    endtask

    task automatic test_empty_tokens();
        send_item(8'h00, 1'b0, 1'b1);
        // empty wins over char and last
        send_item(8'hff, 1'b1, 1'b1);
        // partial token is dropped by an empty one
        send_item(8'h05, 1'b0, 1'b0);
        send_item(8'h86, 1'b0, 1'b0);
        send_item(8'h5a, 1'b1, 1'b1);
    endtask

    task automatic test_dimension_limits();
        set_dimension(7'd0);      // acts as 1
        send_item(8'h33, 1'b1, 1'b0);
        set_dimension(7'd127);    // clamps to 64
        send_item(8'h00, 1'b0, 1'b1);
        set_dimension(7'd65);
        send_item(8'hc3, 1'b1, 1'b0);
        set_dimension(7'd1);
        send_item(8'h10, 1'b0, 1'b0);
        send_item(8'hf0, 1'b1, 1'b0);
    endtask

    task automatic test_random_tokens();
        int items;
        int len;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       set_dimension(7'($urandom_range(1, 8)));
                2:       set_dimension(7'($urandom_range(1, 16)));
                default: set_dimension(7'($urandom_range(0, 127)));
            endcase
            tx_bursty  = (phase != 0);
            burst_left = 0;
            items      = 0;
            while (items < 22) begin
                case ($urandom_range(0, 9))
                    0: begin
                        send_item(random_char(), 1'($urandom_range(0, 1)), 1'b1);
                        items++;
                    end
                    1: begin
                        // cut-off token
                        len = $urandom_range(1, 3);
                        for (int k = 0; k < len; k++)
                            send_item(random_char(), 1'b0, 1'b0);
                        send_item(random_char(), 1'($urandom_range(0, 1)), 1'b1);
                        items += len + 1;
                    end
                    default: begin
                        len = $urandom_range(1, 6);
                        send_token(len);
                        items += len;
                    end
                endcase
            end
        end
        set_dimension(hte_pkg::DIM_RESET);
        tx_bursty = 1'b1;
        send_token(4);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        s_tuser     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        error_count = 0;
        burst_left  = 0;
        tx_bursty   = 1'b0;
        dim_reg     = hte_pkg::DIM_RESET;
        clear_token_state();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_dimension();
        tx_bursty = 1'b1;
        test_char_extremes();
        test_empty_tokens();
        test_dimension_limits();
        test_random_tokens();

        wait_drained();
        repeat (20) @(negedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: hashed_token_embedding.f
+incdir+rtl/core
rtl/core/hte_pkg.sv
rtl/core/hashed_token_embedding.sv
tb/hashed_token_embedding_tb.sv
